### src/seven_segment_octal_display_driver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment display driver
// Concurrent checks; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_OCTAL_DISPLAY_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_OCTAL_DISPLAY_DRIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expr holds at every edge outside reset
`define SSOD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: always");

// cons holds in the same cycle as ante
`define SSOD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// cons holds in the cycle after ante
`define SSOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SSOD_ASSERT_ALWAYS(label, clk, rst, expr)
`define SSOD_ASSERT_SAME(label, clk, rst, ante, cons)
`define SSOD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/ssod_pkg.sv
// ----------------------------------------------------------------------------
// ssod_pkg
// Types, codes and glyph table of the seven-segment display driver.
// ----------------------------------------------------------------------------
package ssod_pkg;

   localparam int NUM_W = 28;
   localparam int MAG_W = 27;

   localparam logic [7:0] BLANK_BYTE  = 8'hFF;
   localparam logic [4:0] DASH_CODE   = 5'd16;
   localparam logic [4:0] GLYPH_COUNT = 5'd17;
   localparam logic [7:0] POINT_CLEAR = 8'h80;
   localparam logic [7:0] POINT_SET   = 8'h7F;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_F = 8'h46;
   localparam logic [7:0] ASCII_DASH    = 8'h2D;
   // ceil(2^35 / 10): exact quotient by ten for any 32-bit dividend
   localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
   localparam int DIV10_SHIFT = 35;

   typedef enum logic [2:0] {
      MODE_GLYPH   = 3'd0,
      MODE_LETTER  = 3'd1,
      MODE_POINT   = 3'd2,
      MODE_NOPOINT = 3'd3,
      MODE_SHOW    = 3'd4,
      MODE_BLANK   = 3'd5,
      MODE_REFRESH = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_DIVIDE,
      ST_DASH,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]              mode;
      logic [2:0]              place;
      logic [4:0]              glyph;
      logic [7:0]              letter;
      logic signed [NUM_W-1:0] number;
   } req_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [7:0] digit_select;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] glyph_rom(input logic [4:0] code);
      logic [7:0] seg;
      case (code)
         5'd0:    seg = 8'hC0;
         5'd1:    seg = 8'hF9;
         5'd2:    seg = 8'hA4;
         5'd3:    seg = 8'hB0;
         5'd4:    seg = 8'h99;
         5'd5:    seg = 8'h92;
         5'd6:    seg = 8'h82;
         5'd7:    seg = 8'hF8;
         5'd8:    seg = 8'h80;
         5'd9:    seg = 8'h90;
         5'd10:   seg = 8'h88;
         5'd11:   seg = 8'h83;
         5'd12:   seg = 8'hC6;
         5'd13:   seg = 8'hA1;
         5'd14:   seg = 8'h86;
         5'd15:   seg = 8'h8E;
         5'd16:   seg = 8'hBF;
         default: seg = BLANK_BYTE;
      endcase
      return seg;
   endfunction

   // elaboration-time power of ten
   function automatic longint pow10(input int n);
      longint r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r;
   endfunction

endpackage

### src/seven_segment_octal_display_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_octal_display_driver
// Holds the segment bytes of a multiplexed common-anode display, writes
// digits, points and decimal numbers, and scans the digits out as frames.
// ----------------------------------------------------------------------------
//  channel   ports                          transfer
//  request   start, busy, req_data          start && !busy
//  result    rsp_valid, rsp_data            rsp_valid, one frame per cycle
//
//  Set glyph, set letter and the point commands finish in the accept cycle.
//  Blank and refresh keep busy high for the scan, one frame per digit.
//  Show number runs after accept through one clamp step, then one digit per
//  pass through the shared divide-by-ten unit (n passes, n = digits of the
//  value, 1..DIGITS), a sign step, then the scan.
//  Reset blanks every digit and returns the sequencer to idle.
//  Frames go out on consecutive cycles; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module seven_segment_octal_display_driver #(
   parameter int DIGITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssod_pkg::req_type req_data,
   output logic              rsp_valid,
   output ssod_pkg::rsp_type rsp_data
);
   import ssod_pkg::*;

   `include "seven_segment_octal_display_driver_assert.svh"

   localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CNT_W = $clog2(DIGITS + 1);
   localparam logic signed [NUM_W-1:0] NUM_MAX = NUM_W'(pow10(DIGITS) - 1);
   localparam logic signed [NUM_W-1:0] NUM_MIN = NUM_W'(-(pow10(DIGITS - 1) - 1));

   state_type               state_ff, state_in;
   logic [7:0]              digit_ff [DIGITS];
   logic [7:0]              digit_in [DIGITS];
   logic signed [NUM_W-1:0] number_ff, number_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;

   logic                    accept;
   logic                    place_ok;
   logic [4:0]              letter_code;
   logic signed [NUM_W-1:0] clamped;
   logic [MAG_W+31:0]       prod;
   logic [MAG_W-1:0]        quot;
   logic [3:0]              rem;

   assign accept   = start && !busy;
   assign place_ok = {1'b0, req_data.place} < 4'(DIGITS);
   assign letter_code = 5'(req_data.letter - ASCII_UPPER_A + 8'd10);

   // shared divide-by-ten unit: quotient by reciprocal, remainder by shift-add
   assign prod = (MAG_W + 32)'(mag_ff) * (MAG_W + 32)'(DIV10_RECIP);
   assign quot = MAG_W'(prod >> DIV10_SHIFT);
   assign rem  = 4'(mag_ff - MAG_W'((quot << 3) + (quot << 1)));

   always_comb begin
      if (number_ff > NUM_MAX) begin
         clamped = NUM_MAX;
      end else if (number_ff < NUM_MIN) begin
         clamped = NUM_MIN;
      end else begin
         clamped = number_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      number_in = number_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      pos_in    = pos_ff;
      scan_in   = scan_ff;
      for (int i = 0; i < DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_in   = '0;
               number_in = req_data.number;
               case (req_data.mode)
                  MODE_GLYPH: begin
                     for (int i = 0; i < DIGITS; i++) begin
                        if (place_ok && req_data.place == 3'(i)
                            && req_data.glyph < GLYPH_COUNT) begin
                           digit_in[i] = glyph_rom(req_data.glyph);
                        end
                     end
                  end
                  MODE_LETTER: begin
                     for (int i = 0; i < DIGITS; i++) begin
                        if (place_ok && req_data.place == 3'(i)) begin
                           if (req_data.letter >= ASCII_UPPER_A
                               && req_data.letter <= ASCII_UPPER_F) begin
                              digit_in[i] = glyph_rom(letter_code);
                           end else if (req_data.letter == ASCII_DASH) begin
                              digit_in[i] = glyph_rom(DASH_CODE);
                           end
                        end
                     end
                  end
                  MODE_POINT: begin
                     for (int i = 0; i < DIGITS; i++) begin
                        if (place_ok && req_data.place == 3'(i)) begin
                           digit_in[i] = digit_ff[i] & POINT_SET;
                        end
                     end
                  end
                  MODE_NOPOINT: begin
                     for (int i = 0; i < DIGITS; i++) begin
                        if (place_ok && req_data.place == 3'(i)) begin
                           digit_in[i] = digit_ff[i] | POINT_CLEAR;
                        end
                     end
                  end
                  MODE_SHOW: begin
                     state_in = ST_CLAMP;
                  end
                  MODE_BLANK: begin
                     for (int i = 0; i < DIGITS; i++) begin
                        digit_in[i] = BLANK_BYTE;
                     end
                     state_in = ST_SCAN;
                  end
                  MODE_REFRESH: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLAMP: begin
            // blank the whole display; the number overwrites from the right
            for (int i = 0; i < DIGITS; i++) begin
               digit_in[i] = BLANK_BYTE;
            end
            neg_in   = clamped[NUM_W-1];
            mag_in   = clamped[NUM_W-1] ? MAG_W'(-clamped) : MAG_W'(clamped);
            pos_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            digit_in[pos_ff[IDX_W-1:0]] = glyph_rom(5'(rem));
            mag_in = quot;
            pos_in = pos_ff + 1'b1;
            if (quot == '0 || pos_ff == CNT_W'(DIGITS - 1)) begin
               state_in = ST_DASH;
            end
         end
         ST_DASH: begin
            if (neg_ff && pos_ff < CNT_W'(DIGITS)) begin
               digit_in[pos_ff[IDX_W-1:0]] = glyph_rom(DASH_CODE);
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rsp_valid = 1'b1;
            if (scan_ff == IDX_W'(DIGITS - 1)) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_data.segments     = digit_ff[scan_ff];
   assign rsp_data.digit_select = 8'(8'd1 << scan_ff);
   assign rsp_data.last         = (scan_ff == IDX_W'(DIGITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         pos_ff   <= '0;
         neg_ff   <= 1'b0;
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= BLANK_BYTE;
         end
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         for (int i = 0; i < DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      number_ff <= number_in;
      mag_ff    <= mag_in;
   end

   `SSOD_ASSERT_ALWAYS(a_strobe_while_busy, clock, reset, !rsp_valid || busy)
   `SSOD_ASSERT_SAME(a_select_onehot, clock, reset, rsp_valid, $onehot(rsp_data.digit_select))
   `SSOD_ASSERT_NEXT(a_scan_continues, clock, reset, rsp_valid && !rsp_data.last, rsp_valid)
   `SSOD_ASSERT_NEXT(a_scan_ends, clock, reset, rsp_valid && rsp_data.last, !rsp_valid && !busy)
   `SSOD_ASSERT_NEXT(a_refresh_starts, clock, reset, accept && req_data.mode == MODE_REFRESH, rsp_valid && rsp_data.digit_select == 8'd1)

endmodule
